// ===== hdl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared constants, the divider stage type and the divider stage function
// for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

	localparam int COMP_BITS       = 8;
	localparam int HUE_BITS        = 15;
	localparam int SAT_BITS        = 17;
	localparam int SAT_FRAC        = 16;
	localparam int OFF_BITS        = 12;
	localparam int SEXTANT         = 3840;
	localparam int HUE_FULL        = 6 * SEXTANT;
	localparam int SAT_STEPS       = SAT_FRAC + 1;
	localparam int OFF_STEPS       = OFF_BITS;
	localparam int STEPS_PER_STAGE = 3;
	localparam int DIV_STAGES      = (SAT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int PROD_BITS       = COMP_BITS + OFF_BITS;

	typedef struct packed {
		logic [COMP_BITS-1:0] bright;
		logic [COMP_BITS-1:0] delta;
		logic [COMP_BITS-1:0] sat_rem;
		logic [SAT_STEPS-1:0] sat_feed;
		logic [SAT_BITS-1:0]  sat_quo;
		logic [COMP_BITS-1:0] off_rem;
		logic [OFF_STEPS-1:0] off_feed;
		logic [OFF_BITS-1:0]  off_quo;
		logic [HUE_BITS-1:0]  hue_base;
		logic                 hue_neg;
		logic                 black;
		logic                 gray;
	} div_stage_t;

	// Several restoring steps of both long divisions.
	function automatic div_stage_t div_step(input div_stage_t x, input int unsigned stage);
		div_stage_t          y;
		logic [COMP_BITS:0]  trial;
		y = x;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			if (int'(stage) * STEPS_PER_STAGE + s < SAT_STEPS) begin
				trial = {y.sat_rem, y.sat_feed[SAT_STEPS-1]};
				if (trial >= {1'b0, y.bright}) begin
					y.sat_rem = COMP_BITS'(trial - {1'b0, y.bright});
					y.sat_quo = {y.sat_quo[SAT_BITS-2:0], 1'b1};
				end else begin
					y.sat_rem = trial[COMP_BITS-1:0];
					y.sat_quo = {y.sat_quo[SAT_BITS-2:0], 1'b0};
				end
				y.sat_feed = {y.sat_feed[SAT_STEPS-2:0], 1'b0};
			end
			if (int'(stage) * STEPS_PER_STAGE + s < OFF_STEPS) begin
				trial = {y.off_rem, y.off_feed[OFF_STEPS-1]};
				if (trial >= {1'b0, y.delta}) begin
					y.off_rem = COMP_BITS'(trial - {1'b0, y.delta});
					y.off_quo = {y.off_quo[OFF_BITS-2:0], 1'b1};
				end else begin
					y.off_rem = trial[COMP_BITS-1:0];
					y.off_quo = {y.off_quo[OFF_BITS-2:0], 1'b0};
				end
				y.off_feed = {y.off_feed[OFF_STEPS-2:0], 1'b0};
			end
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Converts one RGB pixel to hue (1/64 degree), saturation (x65536) and value.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// input    | in_valid, in_ready  | red, green, blue
// output   | out_valid, out_ready| hue_sixtyfourths, saturation_frac, brightness
//
// One pixel per cycle sustained while the output is not stalled; the registers
// are the sextant decode, the divider setup, the divider stages and the output,
// with three quotient bits per divider stage over the 17-bit saturation quotient.
// Reset clears the stage valid bits only.
// A stalled output holds; bubbles collapse, since each stage loads when
// it is empty or the stage after it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [rgbhsv_pkg::COMP_BITS-1:0]      red,
	input  wire  [rgbhsv_pkg::COMP_BITS-1:0]      green,
	input  wire  [rgbhsv_pkg::COMP_BITS-1:0]      blue,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [rgbhsv_pkg::HUE_BITS-1:0]       hue_sixtyfourths,
	output logic [rgbhsv_pkg::SAT_BITS-1:0]       saturation_frac,
	output logic [rgbhsv_pkg::COMP_BITS-1:0]      brightness
);

	localparam int CB = rgbhsv_pkg::COMP_BITS;
	localparam int HB = rgbhsv_pkg::HUE_BITS;
	localparam int NS = rgbhsv_pkg::DIV_STAGES;

	// stage 1: sextant decode
	logic          valid_s1;
	logic [CB-1:0] mx_s1, d_s1, num_s1;
	logic [HB-1:0] base_s1;
	logic          neg_s1;

	logic [CB-1:0] mx_c, mn_c, num_c;
	logic [HB-1:0] base_c;
	logic          neg_c;

	// stage 2: divider setup; div_s[k] is stage k + 3
	logic                   valid_s2;
	rgbhsv_pkg::div_stage_t init_s2;
	rgbhsv_pkg::div_stage_t init_c;
	logic [rgbhsv_pkg::PROD_BITS-1:0] prod_c;

	logic                   div_valid_s [NS];
	rgbhsv_pkg::div_stage_t div_s       [NS];
	logic [NS-1:0]          div_load;
	logic [NS-1:0]          div_next_ready;

	logic load_s1, load_s2, load_out;

	rgbhsv_pkg::div_stage_t last_c;
	logic [HB-1:0]          hue_c;

	assign load_out = !out_valid || out_ready;
	assign load_s2  = !valid_s2 || div_load[0];
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	always_comb begin
		mx_c = (red > green) ? red : green;
		if (blue > mx_c)
			mx_c = blue;
		mn_c = (red < green) ? red : green;
		if (blue < mn_c)
			mn_c = blue;
		priority if (mx_c == red) begin
			if (mn_c == green) begin
				base_c = HB'(5 * rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b0;
				num_c  = mx_c - blue;
			end else begin
				base_c = HB'(rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b1;
				num_c  = mx_c - green;
			end
		end else if (mx_c == green) begin
			if (mn_c == blue) begin
				base_c = HB'(rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b0;
				num_c  = mx_c - red;
			end else begin
				base_c = HB'(3 * rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b1;
				num_c  = mx_c - blue;
			end
		end else begin
			if (mn_c == red) begin
				base_c = HB'(3 * rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b0;
				num_c  = mx_c - green;
			end else begin
				base_c = HB'(5 * rgbhsv_pkg::SEXTANT);
				neg_c  = 1'b1;
				num_c  = mx_c - red;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			mx_s1   <= mx_c;
			d_s1    <= mx_c - mn_c;
			num_s1  <= num_c;
			base_s1 <= base_c;
			neg_s1  <= neg_c;
		end
	end

	always_comb begin
		prod_c = rgbhsv_pkg::PROD_BITS'(num_s1) *
			rgbhsv_pkg::PROD_BITS'(rgbhsv_pkg::SEXTANT);
		init_c          = '0;
		init_c.bright   = mx_s1;
		init_c.delta    = d_s1;
		init_c.sat_rem  = d_s1 >> 1;
		init_c.sat_feed = {d_s1[0], {rgbhsv_pkg::SAT_FRAC{1'b0}}};
		init_c.off_rem  = prod_c[rgbhsv_pkg::PROD_BITS-1:rgbhsv_pkg::OFF_BITS];
		init_c.off_feed = prod_c[rgbhsv_pkg::OFF_BITS-1:0];
		init_c.hue_base = base_s1;
		init_c.hue_neg  = neg_s1;
		init_c.black    = (mx_s1 == '0);
		init_c.gray     = (d_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1)
			init_s2 <= init_c;
	end

	for (genvar k = 0; k < NS; k++) begin : g_div
		if (k == NS - 1) begin : g_tail
			assign div_next_ready[k] = load_out;
		end else begin : g_body
			assign div_next_ready[k] = div_load[k+1];
		end
		assign div_load[k] = !div_valid_s[k] || div_next_ready[k];

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_valid_s[k] <= 1'b0;
				end else if (div_load[k]) begin
					div_valid_s[k] <= valid_s2;
				end
			end
			always_ff @(posedge clk) begin
				if (div_load[k] && valid_s2)
					div_s[k] <= rgbhsv_pkg::div_step(init_s2, k);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_valid_s[k] <= 1'b0;
				end else if (div_load[k]) begin
					div_valid_s[k] <= div_valid_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (div_load[k] && div_valid_s[k-1])
					div_s[k] <= rgbhsv_pkg::div_step(div_s[k-1], k);
			end
		end
	end

	always_comb begin
		last_c = div_s[NS-1];
		if (last_c.gray)
			hue_c = '0;
		else if (last_c.hue_neg)
			hue_c = last_c.hue_base - HB'(last_c.off_quo);
		else
			hue_c = last_c.hue_base + HB'(last_c.off_quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= div_valid_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && div_valid_s[NS-1]) begin
			hue_sixtyfourths <= hue_c;
			saturation_frac  <= last_c.black ? '0 : last_c.sat_quo;
			brightness       <= last_c.bright;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rgbhsv_checker.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks on the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire [rgbhsv_pkg::HUE_BITS-1:0]      hue_sixtyfourths,
	input wire [rgbhsv_pkg::SAT_BITS-1:0]      saturation_frac,
	input wire [rgbhsv_pkg::COMP_BITS-1:0]     brightness
);

	localparam int HB = rgbhsv_pkg::HUE_BITS;
	localparam int SB = rgbhsv_pkg::SAT_BITS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue_sixtyfourths) &&
			$stable(saturation_frac) && $stable(brightness))
		else $error("output item changed while stalled");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue_sixtyfourths <= HB'(rgbhsv_pkg::HUE_FULL))
		else $error("hue beyond full circle");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> saturation_frac <= SB'(1 << rgbhsv_pkg::SAT_FRAC))
		else $error("saturation beyond one");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> saturation_frac == '0 && hue_sixtyfourths == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation_frac == '0 |-> hue_sixtyfourths == '0)
		else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker u_rgbhsv_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.hue_sixtyfourths (hue_sixtyfourths),
	.saturation_frac  (saturation_frac),
	.brightness       (brightness)
);

`default_nettype wire
